// ===== hw/rtl/block_isometry_scatter_addresses_assert.svh =====
// ----------------------------------------------------------------------------
// Block isometry scatter addresses - assertion macros
// Same-cycle and next-cycle implications clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_ISOMETRY_SCATTER_ADDRESSES_ASSERT_SVH
`define BLOCK_ISOMETRY_SCATTER_ADDRESSES_ASSERT_SVH

// cons must hold in the same cycle as ante
`define BISA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// cons must hold in the cycle after ante
`define BISA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/bisa_pkg.sv =====
// ----------------------------------------------------------------------------
// Block isometry scatter addresses - package
// Widths, register codes, symmetry table and the remainder step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bisa_pkg;

   // image side cap and the widths that follow from it
   localparam int MAX_SIDE = 1024;
   localparam int SIDE_W   = $clog2(MAX_SIDE + 1);

   // fixed field widths
   localparam int POS_W     = 10;
   localparam int PIX_W     = 32;
   localparam int ADDR_W    = 23;
   localparam int REG_W     = 11;
   localparam int CSR_IDX_W = 2;
   localparam int NUM_SYM   = 8;
   localparam int SYM_W     = 3;

   // transformed coordinate: origin plus up to reflect_sum, may go negative
   localparam int COORD_W = REG_W + 2;
   // plane * side^2 + row * side + column stays below 8 * side^2
   localparam int SUM_W   = SYM_W + 2 * SIDE_W;

   // remainder pipeline: two dividend bits per stage
   localparam int FRONT_STAGES = POS_W / 2;

   // stream widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * POS_W + PIX_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((ADDR_W + PIX_W + 7) / 8) * 8;
   localparam int RSP_USER_W = SYM_W + 1;

   localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(NUM_SYM - 1);

   // register reset values
   localparam logic [REG_W-1:0] IMAGE_SIDE_RST  = REG_W'(256);
   localparam logic [REG_W-1:0] BLOCK_SIDE_RST  = REG_W'(8);
   localparam logic [REG_W-1:0] REFLECT_SUM_RST = REG_W'(7);

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_SIDE  = 2'd0,
      CSR_BLOCK_SIDE  = 2'd1,
      CSR_REFLECT_SUM = 2'd2
   } csr_reg_type;

   // source of one transformed local coordinate
   typedef enum logic [1:0] {
      SEL_MX  = 2'd0,
      SEL_MY  = 2'd1,
      SEL_RMX = 2'd2,
      SEL_RMY = 2'd3
   } coord_sel_type;

   // item leaving the remainder pipeline
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos_x;
      logic [POS_W-1:0] pos_y;
      logic [POS_W-1:0] rem_x;
      logic [POS_W-1:0] rem_y;
      logic [PIX_W-1:0] pixel;
   } bisa_item_type;

   // column source per symmetry
   function automatic coord_sel_type sym_x_sel(input logic [SYM_W-1:0] k);
      coord_sel_type sel;
      unique case (k)
         3'd0:    sel = SEL_MX;
         3'd1:    sel = SEL_MY;
         3'd2:    sel = SEL_RMX;
         3'd3:    sel = SEL_RMY;
         3'd4:    sel = SEL_MY;
         3'd5:    sel = SEL_RMY;
         3'd6:    sel = SEL_RMX;
         default: sel = SEL_MX;
      endcase
      return sel;
   endfunction

   // row source per symmetry
   function automatic coord_sel_type sym_y_sel(input logic [SYM_W-1:0] k);
      coord_sel_type sel;
      unique case (k)
         3'd0:    sel = SEL_MY;
         3'd1:    sel = SEL_RMX;
         3'd2:    sel = SEL_RMY;
         3'd3:    sel = SEL_MX;
         3'd4:    sel = SEL_MX;
         3'd5:    sel = SEL_RMX;
         3'd6:    sel = SEL_MY;
         default: sel = SEL_RMY;
      endcase
      return sel;
   endfunction

   // one restoring step: shift in a dividend bit, subtract if it fits
   function automatic logic [REG_W-1:0] rem_step(input logic [REG_W-1:0] rem,
                                                 input logic             din,
                                                 input logic [REG_W-1:0] divisor);
      logic [REG_W:0] t;
      logic [REG_W:0] d;
      t = {rem, din};
      d = {1'b0, divisor};
      if (t >= d) begin
         t = t - d;
      end
      return t[REG_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/block_isometry_scatter_addresses.sv =====
// ----------------------------------------------------------------------------
// Block isometry scatter addresses - top level
// Eight symmetry scatter writes per pixel, with in-image flags.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one pixel per item: position and 32 raw value bits.
//   rsp_ returns eight items per pixel, symmetry 0 to 7 in order, tlast on
//   symmetry 7. Each gives the scatter address (0 when out of the image), the
//   pixel bits, the symmetry number and the in-image flag.
//   csr_ writes image_side, block_side and reflect_sum; write only while idle.
// Path: the first result of a pixel passes 5 remainder stages, the symmetry
//   sequencer, 2 address stages and the output register.
// Throughput: one result per cycle while rsp_tready is high; the sequencer
//   steps through the eight symmetries per pixel. New pixels move through the
//   remainder pipeline until one of them waits at its end for the sequencer.
// Reset: registers go to 256 / 8 / 7 and all pipeline contents are dropped.
// Stall: while a result waits and rsp_tready is low, the sequencer and the
//   stages behind it hold; req_tready is low while the pixel at the end of
//   the remainder pipeline waits for the sequencer. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module block_isometry_scatter_addresses (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // pos_x [9:0], pos_y [19:10], pixel_bits [51:20], zero pad
   input  wire logic [bisa_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // scatter_address [22:0], pixel_out [54:23], zero pad
   output logic [bisa_pkg::RSP_DATA_W-1:0]            rsp_tdata,
   // symmetry_index [2:0], in_range [3]
   output logic [bisa_pkg::RSP_USER_W-1:0]            rsp_tuser,
   output logic                                       rsp_tlast,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_we,
   input  wire logic [bisa_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [bisa_pkg::REG_W-1:0]            csr_wdata
);
   import bisa_pkg::*;

   localparam int CMP_W = COORD_W + SIDE_W;

   // configuration
   logic [REG_W-1:0]    image_side_ff;
   logic [REG_W-1:0]    block_side_ff;
   logic [REG_W-1:0]    reflect_sum_ff;
   logic [REG_W-1:0]    bs_eff;
   logic [SIDE_W-1:0]   side;
   logic [REG_W+SIDE_W-1:0] side_wide;
   logic [REG_W+SIDE_W-1:0] side_cap;
   logic [2*SIDE_W-1:0] side_sq_ff;

   // flow control
   logic                adv;
   logic                ser_take;
   logic                front_en;
   bisa_item_type       front_item;

   // symmetry sequencer
   logic                ser_valid_ff;
   logic [SYM_W-1:0]    ser_k_ff;
   logic [POS_W-1:0]    ser_mx_ff;
   logic [POS_W-1:0]    ser_my_ff;
   logic [POS_W-1:0]    ser_ox_ff;
   logic [POS_W-1:0]    ser_oy_ff;
   logic [PIX_W-1:0]    ser_pix_ff;

   // stage A: transformed coordinates
   logic                a_valid_ff;
   logic [SYM_W-1:0]    a_k_ff;
   logic [COORD_W-1:0]  a_gx_ff;
   logic [COORD_W-1:0]  a_gy_ff;
   logic [PIX_W-1:0]    a_pix_ff;
   logic [COORD_W-1:0]  gx_in;
   logic [COORD_W-1:0]  gy_in;

   // stage B: range check and products
   logic                b_valid_ff;
   logic [SYM_W-1:0]    b_k_ff;
   logic                b_ok_ff;
   logic [SUM_W-1:0]    b_plane_ff;
   logic [SUM_W-1:0]    b_row_ff;
   logic [COORD_W-2:0]  b_gx_ff;
   logic [PIX_W-1:0]    b_pix_ff;
   logic                ok_in;

   // output register
   logic                o_valid_ff;
   logic [SYM_W-1:0]    o_k_ff;
   logic                o_ok_ff;
   logic [ADDR_W-1:0]   o_addr_ff;
   logic [PIX_W-1:0]    o_pix_ff;
   logic [SUM_W-1:0]    addr_sum;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         image_side_ff  <= IMAGE_SIDE_RST;
         block_side_ff  <= BLOCK_SIDE_RST;
         reflect_sum_ff <= REFLECT_SUM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IMAGE_SIDE:  image_side_ff  <= csr_wdata;
            CSR_BLOCK_SIDE:  block_side_ff  <= csr_wdata;
            CSR_REFLECT_SUM: reflect_sum_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // block side zero acts as one; image side saturates at the cap
   always_comb begin
      bs_eff    = (block_side_ff == '0) ? REG_W'(1) : block_side_ff;
      side_wide = (REG_W+SIDE_W)'(image_side_ff);
      side_cap  = (REG_W+SIDE_W)'(MAX_SIDE);
      side      = SIDE_W'((side_wide > side_cap) ? side_cap : side_wide);
   end

   // side squared, settled long before any item needs it
   always_ff @(posedge clock) begin
      side_sq_ff <= (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
   end

   // everything behind the sequencer moves together with the output
   always_comb begin
      adv      = !o_valid_ff || rsp_tready;
      ser_take = adv && (!ser_valid_ff || (ser_k_ff == LAST_SYM));
      front_en = !front_item.valid || ser_take;
   end

   assign req_tready = front_en;

   bisa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (front_en),
      .in_valid (req_tvalid),
      .pos_x    (req_tdata[POS_W-1:0]),
      .pos_y    (req_tdata[2*POS_W-1:POS_W]),
      .pixel    (req_tdata[2*POS_W+PIX_W-1:2*POS_W]),
      .divisor  (bs_eff),
      .out_item (front_item)
   );

   // sequencer: holds one pixel and steps through the symmetries
   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
         ser_k_ff     <= '0;
      end else if (ser_take) begin
         ser_valid_ff <= front_item.valid;
         ser_k_ff     <= '0;
      end else if (adv && ser_valid_ff) begin
         ser_k_ff     <= ser_k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (ser_take) begin
         ser_mx_ff  <= front_item.rem_x;
         ser_my_ff  <= front_item.rem_y;
         ser_ox_ff  <= front_item.pos_x - front_item.rem_x;
         ser_oy_ff  <= front_item.pos_y - front_item.rem_y;
         ser_pix_ff <= front_item.pixel;
      end
   end

   // local coordinate chosen by the symmetry table, two's complement
   function automatic logic [COORD_W-1:0] local_term(input coord_sel_type sel,
                                                     input logic [POS_W-1:0] mx,
                                                     input logic [POS_W-1:0] my,
                                                     input logic [REG_W-1:0] r);
      logic [COORD_W-1:0] t;
      case (sel)
         SEL_MX:  t = COORD_W'(mx);
         SEL_MY:  t = COORD_W'(my);
         SEL_RMX: t = COORD_W'(r) - COORD_W'(mx);
         default: t = COORD_W'(r) - COORD_W'(my);
      endcase
      return t;
   endfunction

   // stage A: add the block origin back
   always_comb begin
      gx_in = COORD_W'(ser_ox_ff)
            + local_term(sym_x_sel(ser_k_ff), ser_mx_ff, ser_my_ff, reflect_sum_ff);
      gy_in = COORD_W'(ser_oy_ff)
            + local_term(sym_y_sel(ser_k_ff), ser_mx_ff, ser_my_ff, reflect_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= ser_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_k_ff   <= ser_k_ff;
         a_gx_ff  <= gx_in;
         a_gy_ff  <= gy_in;
         a_pix_ff <= ser_pix_ff;
      end
   end

   // stage B: in-image check, row offset and plane base
   always_comb begin
      ok_in = !a_gx_ff[COORD_W-1] && !a_gy_ff[COORD_W-1]
           && (CMP_W'(a_gx_ff[COORD_W-2:0]) < CMP_W'(side))
           && (CMP_W'(a_gy_ff[COORD_W-2:0]) < CMP_W'(side));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         b_k_ff     <= a_k_ff;
         b_ok_ff    <= ok_in;
         b_plane_ff <= SUM_W'(a_k_ff) * SUM_W'(side_sq_ff);
         b_row_ff   <= SUM_W'(a_gy_ff[COORD_W-2:0]) * SUM_W'(side);
         b_gx_ff    <= a_gx_ff[COORD_W-2:0];
         b_pix_ff   <= a_pix_ff;
      end
   end

   // output register: final address sum, zero when out of the image
   assign addr_sum = b_plane_ff + b_row_ff + SUM_W'(b_gx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (adv) begin
         o_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         o_k_ff    <= b_k_ff;
         o_ok_ff   <= b_ok_ff;
         o_addr_ff <= b_ok_ff ? addr_sum[ADDR_W-1:0] : '0;
         o_pix_ff  <= b_pix_ff;
      end
   end

   always_comb begin
      rsp_tvalid = o_valid_ff;
      rsp_tdata  = RSP_DATA_W'({o_pix_ff, o_addr_ff});
      rsp_tuser  = {o_ok_ff, o_k_ff};
      rsp_tlast  = (o_k_ff == LAST_SYM);
   end

   // checks
`include "block_isometry_scatter_addresses_assert.svh"

   `BISA_ASSERT_NOW(a_out_of_image_zero, o_valid_ff && !o_ok_ff, o_addr_ff == '0, "out-of-image result with nonzero address")
   `BISA_ASSERT_NOW(a_no_take_mid_pixel, ser_valid_ff && (ser_k_ff != LAST_SYM), !ser_take, "sequencer reloaded before its last symmetry")
   `BISA_ASSERT_NEXT(a_sym_in_order, o_valid_ff && rsp_tready && (o_k_ff != LAST_SYM), !o_valid_ff || (o_k_ff == SYM_W'($past(o_k_ff) + 1'b1)), "symmetry results out of order")
   `BISA_ASSERT_NOW(a_front_held_on_stall, front_item.valid && !ser_take, !req_tready, "remainder pipeline moved while full and blocked")

endmodule

`default_nettype wire

// ===== hw/rtl/bisa_front.sv =====
// ----------------------------------------------------------------------------
// Block isometry scatter addresses - remainder pipeline
// Takes pos_x and pos_y modulo the block side, two bits per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bisa_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              enable,
   input  wire logic                              in_valid,
   input  wire logic [bisa_pkg::POS_W-1:0]        pos_x,
   input  wire logic [bisa_pkg::POS_W-1:0]        pos_y,
   input  wire logic [bisa_pkg::PIX_W-1:0]        pixel,
   input  wire logic [bisa_pkg::REG_W-1:0]        divisor,
   output bisa_pkg::bisa_item_type                out_item
);
   import bisa_pkg::*;

   logic                v_ff   [FRONT_STAGES];
   logic [POS_W-1:0]    px_ff  [FRONT_STAGES];
   logic [POS_W-1:0]    py_ff  [FRONT_STAGES];
   logic [REG_W-1:0]    rx_ff  [FRONT_STAGES];
   logic [REG_W-1:0]    ry_ff  [FRONT_STAGES];
   logic [PIX_W-1:0]    pix_ff [FRONT_STAGES];

   // stage inputs: ports for the first stage, previous stage otherwise
   logic                v_src   [FRONT_STAGES];
   logic [POS_W-1:0]    px_src  [FRONT_STAGES];
   logic [POS_W-1:0]    py_src  [FRONT_STAGES];
   logic [REG_W-1:0]    rx_src  [FRONT_STAGES];
   logic [REG_W-1:0]    ry_src  [FRONT_STAGES];
   logic [PIX_W-1:0]    pix_src [FRONT_STAGES];

   for (genvar s = 0; s < FRONT_STAGES; s++) begin : g_stage
      localparam int HI = POS_W - 1 - 2 * s;

      logic [REG_W-1:0] rx_in;
      logic [REG_W-1:0] ry_in;

      if (s == 0) begin : g_first
         assign v_src[s]   = in_valid;
         assign px_src[s]  = pos_x;
         assign py_src[s]  = pos_y;
         assign rx_src[s]  = '0;
         assign ry_src[s]  = '0;
         assign pix_src[s] = pixel;
      end else begin : g_rest
         assign v_src[s]   = v_ff[s-1];
         assign px_src[s]  = px_ff[s-1];
         assign py_src[s]  = py_ff[s-1];
         assign rx_src[s]  = rx_ff[s-1];
         assign ry_src[s]  = ry_ff[s-1];
         assign pix_src[s] = pix_ff[s-1];
      end

      // two dependent restoring steps per coordinate
      always_comb begin
         rx_in = rem_step(rem_step(rx_src[s], px_src[s][HI], divisor),
                          px_src[s][HI-1], divisor);
         ry_in = rem_step(rem_step(ry_src[s], py_src[s][HI], divisor),
                          py_src[s][HI-1], divisor);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (enable) begin
            v_ff[s] <= v_src[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            px_ff[s]  <= px_src[s];
            py_ff[s]  <= py_src[s];
            rx_ff[s]  <= rx_in;
            ry_ff[s]  <= ry_in;
            pix_ff[s] <= pix_src[s];
         end
      end
   end

   // remainder never exceeds the position, so it fits the position width
   always_comb begin
      out_item.valid = v_ff[FRONT_STAGES-1];
      out_item.pos_x = px_ff[FRONT_STAGES-1];
      out_item.pos_y = py_ff[FRONT_STAGES-1];
      out_item.rem_x = rx_ff[FRONT_STAGES-1][POS_W-1:0];
      out_item.rem_y = ry_ff[FRONT_STAGES-1][POS_W-1:0];
      out_item.pixel = pix_ff[FRONT_STAGES-1];
   end

endmodule

`default_nettype wire
